@@ rtl/insertion_sorter_unit_assert.svh @@
// ----------------------------------------------------------------------------
// insertion_sorter_unit assertion macros
// Clocked property checks; compiled out when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef INSERTION_SORTER_UNIT_ASSERT_SVH
`define INSERTION_SORTER_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// plain property on clk, masked during reset
`define ISU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication
`define ISU_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ISU_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ISU_ASSERT(lbl, prop, msg)
`define ISU_ASSERT_IMP(lbl, ante, cons, msg)
`define ISU_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

@@ rtl/isu_pkg.sv @@
// ----------------------------------------------------------------------------
// isu_pkg
// Shared constants and controller-to-datapath command type.
// ----------------------------------------------------------------------------
package isu_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int DATA_W    = 32;

    typedef struct packed {
        logic insert;   // write input value into the cell chain
        logic pop;      // shift chain toward the head by one
    } isu_cmd_t;

endpackage

@@ rtl/isu_datapath.sv @@
// ----------------------------------------------------------------------------
// isu_datapath
// Chain of compare-and-shift cells holding the batch in ascending order.
// ----------------------------------------------------------------------------
module isu_datapath #(
    parameter int DEPTH  = isu_pkg::DEPTH_DEF,
    parameter int FILL_W = $clog2(DEPTH + 1)
) (
    input  logic                                clk,
    input  isu_pkg::isu_cmd_t                   cmd,
    input  logic [FILL_W-1:0]                   fill,
    input  logic signed [isu_pkg::DATA_W-1:0]   in_value,
    output logic signed [isu_pkg::DATA_W-1:0]   head_value
);
    import isu_pkg::*;

    logic signed [DATA_W-1:0] cell_reg [DEPTH];
    logic [DEPTH-1:0]         gt;

    // cell holds a live entry greater than the new value; ties stay in front
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            gt[i] = (FILL_W'(i) < fill) && (cell_reg[i] > in_value);
        end
    end

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic gt_prev;
        logic signed [DATA_W-1:0] prev_value;
        logic signed [DATA_W-1:0] next_value;

        if (i == 0)
        begin : g_head
            assign gt_prev    = 1'b0;
            assign prev_value = in_value;
        end
        else
        begin : g_body
            assign gt_prev    = gt[i-1];
            assign prev_value = cell_reg[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign next_value = cell_reg[i];
        end
        else
        begin : g_mid
            assign next_value = cell_reg[i+1];
        end

        always_ff @(posedge clk)
        begin
            if (cmd.pop)
            begin
                cell_reg[i] <= next_value;
            end
            else if (cmd.insert)
            begin
                if (gt_prev)
                begin
                    cell_reg[i] <= prev_value;
                end
                else if (gt[i] || (FILL_W'(i) == fill))
                begin
                    cell_reg[i] <= in_value;
                end
            end
        end
    end

    assign head_value = cell_reg[0];

endmodule

@@ rtl/isu_ctrl.sv @@
// ----------------------------------------------------------------------------
// isu_ctrl
// Load/emit sequencer: tracks fill count and drop flag, drives handshakes.
// ----------------------------------------------------------------------------
module isu_ctrl #(
    parameter int DEPTH  = isu_pkg::DEPTH_DEF,
    parameter int FILL_W = $clog2(DEPTH + 1)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic                s_tlast,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic                m_tlast,
    output logic                m_tuser,
    output isu_pkg::isu_cmd_t   cmd,
    output logic [FILL_W-1:0]   fill
);
    import isu_pkg::*;

    localparam logic ST_LOAD = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    logic              state_reg, state_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic              drop_reg, drop_next;
    logic              s_acc, m_acc, full;

    assign full     = (fill_reg == FILL_W'(DEPTH));
    assign s_tready = (state_reg == ST_LOAD);
    assign m_tvalid = (state_reg == ST_EMIT);
    assign s_acc    = s_tvalid && s_tready;
    assign m_acc    = m_tvalid && m_tready;
    assign m_tlast  = (fill_reg == FILL_W'(1));
    assign m_tuser  = drop_reg;

    assign cmd.insert = s_acc && !full;
    assign cmd.pop    = m_acc;
    assign fill       = fill_reg;

    always_comb
    begin
        state_next = state_reg;
        fill_next  = fill_reg;
        drop_next  = drop_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (s_acc)
                begin
                    if (full)
                    begin
                        drop_next = 1'b1;
                    end
                    else
                    begin
                        fill_next = fill_reg + FILL_W'(1);
                    end
                    if (s_tlast)
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT:
            begin
                if (m_acc)
                begin
                    fill_next = fill_reg - FILL_W'(1);
                    if (m_tlast)
                    begin
                        state_next = ST_LOAD;
                        drop_next  = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            fill_reg  <= '0;
            drop_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            drop_reg  <= drop_next;
        end
    end

`include "insertion_sorter_unit_assert.svh"

    `ISU_ASSERT(a_fill_bound, fill_reg <= FILL_W'(DEPTH), "fill count above depth")
    `ISU_ASSERT_IMP(a_emit_nonempty, state_reg == ST_EMIT, fill_reg != '0, "emitting empty store")
    `ISU_ASSERT_IMP(a_cmd_excl, cmd.insert, !cmd.pop, "insert and pop together")
    `ISU_ASSERT_NXT(a_last_to_emit, s_acc && s_tlast, state_reg == ST_EMIT, "last item not emitted")
    `ISU_ASSERT_NXT(a_batch_clear, m_acc && m_tlast, fill_reg == '0 && !drop_reg, "batch not cleared")

endmodule

@@ rtl/insertion_sorter_unit.sv @@
// ----------------------------------------------------------------------------
// insertion_sorter_unit
// Stable streaming insertion sort of signed 32-bit values, batch-emitted.
// ----------------------------------------------------------------------------
//  channel   dir  tdata            tlast          tuser
//  s_*       in   value[31:0]      last_item      -
//  m_*       out  sorted_value     end_of_batch   overflowed
//
//  Insert: one item per cycle in load, all cells compare and shift in parallel.
//  Emit: after a last item, n results leave the chain head, one per cycle
//  if m_tready is high; no input is taken until the final result is delivered.
//  Reset clears state, fill count and overflow flag; cell contents undefined.
//  m_tready low holds the head result; s_tvalid low simply idles.
// ----------------------------------------------------------------------------
module insertion_sorter_unit #(
    parameter int DEPTH = isu_pkg::DEPTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic signed [isu_pkg::DATA_W-1:0]   s_tdata,   // [31:0] value
    input  logic                                s_tlast,   // last_item
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic signed [isu_pkg::DATA_W-1:0]   m_tdata,   // [31:0] sorted_value
    output logic                                m_tlast,   // end_of_batch
    output logic                                m_tuser    // [0] overflowed
);
    import isu_pkg::*;

    localparam int FILL_W = $clog2(DEPTH + 1);

    isu_cmd_t          cmd;
    logic [FILL_W-1:0] fill;

    isu_ctrl #(
        .DEPTH  (DEPTH),
        .FILL_W (FILL_W)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .cmd      (cmd),
        .fill     (fill)
    );

    isu_datapath #(
        .DEPTH  (DEPTH),
        .FILL_W (FILL_W)
    ) u_datapath (
        .clk        (clk),
        .cmd        (cmd),
        .fill       (fill),
        .in_value   (s_tdata),
        .head_value (m_tdata)
    );

endmodule

@@ tb/insertion_sorter_unit_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// insertion_sorter_unit_test
// Streams batches of signed values into the sorter and checks every sorted
// item (value, end-of-batch, overflow flag) against a local stable sort.
// Covers extremes, ties, a full store with drops, random batches, an idle-free
// stretch and a long output hold-off that stalls the input side.
// ----------------------------------------------------------------------------
module insertion_sorter_unit_test;

    localparam int SORT_DEPTH  = isu_pkg::DEPTH_DEF;
    localparam int DW          = isu_pkg::DATA_W;
    localparam int CYCLE_LIMIT = 100000;
    localparam int HOLD_CYCLES = 300;
    localparam int IDLE_PCT    = 27;

    typedef struct {
        logic signed [DW-1:0] value;
        logic                 end_of_batch;
        logic                 overflowed;
    } sorted_item_t;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic signed [DW-1:0] s_tdata;    // [31:0] value
    logic                 s_tlast;    // last_item
    logic                 m_tvalid;
    logic                 m_tready;
    logic signed [DW-1:0] m_tdata;    // [31:0] sorted_value
    logic                 m_tlast;    // end_of_batch
    logic                 m_tuser;    // [0] overflowed

    // local copy of the batch being collected
    logic signed [DW-1:0] batch_store [SORT_DEPTH];
    int                   batch_fill;
    bit                   batch_dropped;
    sorted_item_t         pending_sorted [$];

    int  error_count;
    int  cycle_count;
    int  items_sent;
    bit  idle_on;
    bit  hold_request;
    int  hold_left;

    insertion_sorter_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d items outstanding",
                     cycle_count, pending_sorted.size());
            $display("insertion_sorter_unit regression: fail");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        $display("MISMATCH @%0d: %s", cycle_count, what);
        error_count++;
    endtask

    // stable insert: a new value lands after every equal stored value
    task automatic predict_insert(input logic signed [DW-1:0] v, input logic last);
        int pos;
        sorted_item_t r;
        if (batch_fill >= SORT_DEPTH)
            batch_dropped = 1'b1;
        else
        begin
            pos = batch_fill;
            while (pos > 0 && batch_store[pos-1] > v)
            begin
                batch_store[pos] = batch_store[pos-1];
                pos--;
            end
            batch_store[pos] = v;
            batch_fill++;
        end
        if (last)
        begin
            for (int k = 0; k < batch_fill; k++)
            begin
                r.value        = batch_store[k];
                r.end_of_batch = (k == batch_fill - 1);
                r.overflowed   = batch_dropped;
                pending_sorted.push_back(r);
            end
            batch_fill    = 0;
            batch_dropped = 1'b0;
        end
    endtask

    task automatic send_value(input logic signed [DW-1:0] v, input logic last);
        int gap;
        gap = 0;
        if (idle_on)
            while ($urandom_range(0, 99) < IDLE_PCT)
                gap++;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!s_tready);
        predict_insert(v, last);
        items_sent++;
    endtask

    task automatic send_random_batch(input int len);
        logic signed [DW-1:0] v;
        for (int i = 0; i < len; i++)
        begin
            case ($urandom_range(0, 3))
                0: v = $signed($urandom_range(0, 8)) - 4;   // dense ties
                1:
                begin
                    case ($urandom_range(0, 3))
                        0: v = 32'sh8000_0000;
                        1: v = 32'sh7fff_ffff;
                        2: v = 32'sh0;
                        default: v = -32'sd1;
                    endcase
                end
                default: v = $urandom;
            endcase
            send_value(v, i == len - 1);
        end
    endtask

    task automatic test_single_item;
        send_value(32'sh7fff_ffff, 1'b1);
    endtask

    task automatic test_extremes_and_ties;
        send_value(32'sh0,         1'b0);
        send_value(-32'sd1,        1'b0);
        send_value(32'sh8000_0000, 1'b0);
        send_value(32'sh7fff_ffff, 1'b0);
        send_value(32'sh8000_0000, 1'b0);
        send_value(32'sh7fff_ffff, 1'b0);
        send_value(-32'sd1,        1'b1);
    endtask

    // fills the store in descending order, the last item is dropped yet
    // still closes the batch
    task automatic test_full_store;
        for (int i = 0; i < SORT_DEPTH; i++)
            send_value(32'sd1000 - i * 7, 1'b0);
        send_value(32'sd5, 1'b1);
    endtask

    task automatic test_random_batches;
        int start;
        start = items_sent;
        while (items_sent - start < 20)
            send_random_batch(($urandom_range(0, 9) == 0) ? $urandom_range(SORT_DEPTH + 1, 20)
                                                           : $urandom_range(1, SORT_DEPTH));
    endtask

    task automatic test_no_idle_stretch;
        idle_on = 1'b0;
        send_random_batch(SORT_DEPTH);
        send_random_batch(3);
        send_random_batch(SORT_DEPTH + 2);
        idle_on = 1'b1;
    endtask

    task automatic test_output_hold_off;
        hold_request = 1'b1;
        send_random_batch(SORT_DEPTH);
        send_random_batch(4);
    endtask

    // receiver: random stalls, or a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_request)
        begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0)
        begin
            m_tready <= 1'b0;
            hold_left--;
        end
        else if (idle_on)
            m_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        sorted_item_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_sorted.size() == 0)
                report_mismatch($sformatf("unexpected item value=%0d", m_tdata));
            else
            begin
                want = pending_sorted.pop_front();
                if (m_tdata !== want.value)
                    report_mismatch($sformatf("sorted_value got %0d want %0d",
                                              m_tdata, want.value));
                if (m_tlast !== want.end_of_batch)
                    report_mismatch($sformatf("end_of_batch got %b want %b",
                                              m_tlast, want.end_of_batch));
                if (m_tuser !== want.overflowed)
                    report_mismatch($sformatf("overflowed got %b want %b",
                                              m_tuser, want.overflowed));
            end
        end
    end

    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tlast       = 1'b0;
        m_tready      = 1'b0;
        error_count   = 0;
        cycle_count   = 0;
        items_sent    = 0;
        idle_on       = 1'b1;
        hold_request  = 1'b0;
        hold_left     = 0;
        batch_fill    = 0;
        batch_dropped = 1'b0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_single_item();
        test_extremes_and_ties();
        test_full_store();
        test_random_batches();
        test_no_idle_stretch();
        test_output_hold_off();

        s_tvalid <= 1'b0;
        while (pending_sorted.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (error_count == 0)
            $display("insertion_sorter_unit regression: pass");
        else
            $display("insertion_sorter_unit regression: fail");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl
rtl/isu_pkg.sv
rtl/isu_datapath.sv
rtl/isu_ctrl.sv
rtl/insertion_sorter_unit.sv
tb/insertion_sorter_unit_test.sv
